/* sv/kmp_stream_pattern_matcher_assert.svh */
// Assertion macros for the KMP stream pattern matcher.
`ifndef KMP_STREAM_PATTERN_MATCHER_ASSERT_SVH
`define KMP_STREAM_PATTERN_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define KMP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication under reset.
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KMP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/kmp_pkg.sv */
// Shared types, constants and helpers of the KMP stream pattern matcher.
`default_nettype none
package kmp_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int BYTE_W      = 8;
	localparam int IDX_W       = 3;
	localparam int LEN_W       = 4;
	localparam int POS_W       = 16;
	localparam int PAT_W       = 64;
	localparam int OUT_DATA_W  = 24;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [PAT_W-1:0] PATTERN_RESET = 64'h0000_0000_0000_0A0D;
	localparam logic [LEN_W-1:0] LENGTH_RESET  = 4'd2;
	localparam logic [LEN_W-1:0] LENGTH_MAX    = 4'd8;
	localparam logic [POS_W-1:0] POS_CAP       = 16'hFFFF;

	// Register indexes of the configuration port.
	typedef enum logic [0:0] {
		REG_PATTERN = 1'b0,
		REG_LENGTH  = 1'b1
	} cfg_reg_t;

	// Back-end sequencer states.
	typedef enum logic [0:0] {
		BK_IDLE,
		BK_SCAN
	} back_state_t;

	// Table builder states.
	typedef enum logic [0:0] {
		TB_IDLE,
		TB_RUN
	} tbl_state_t;

	// One queued text byte.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} item_t;

	// Active pattern as seen by the matcher.
	typedef struct packed {
		logic [PAT_W-1:0] pattern;
		logic [LEN_W-1:0] len;
	} cfg_t;

	// Table builder status.
	typedef struct packed {
		logic busy;
	} tbl_stat_t;

	// Pick pattern byte k, first byte in the low bits.
	function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] p,
			input logic [IDX_W-1:0] k);
		pat_byte = p[k*BYTE_W +: BYTE_W];
	endfunction

	// Clamp the length register to the pattern capacity.
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
		eff_len = (n > LENGTH_MAX) ? LENGTH_MAX : n;
	endfunction

endpackage
`default_nettype wire

/* sv/kmp_stream_pattern_matcher.sv */
// Top level of the KMP stream pattern matcher.
//
//   port group   dir   payload
//   s_*          in    tdata = data_byte[7:0]; tlast = last_byte
//   m_*          out   tdata = match_here, match_start[16:1], no_match[17]; tlast = text_end
//   cfg_*        in    index 0 pattern[63:0], index 1 pattern_length[3:0]
//
// Each byte is fetched in the idle state; the scan state then does one KMP fallback
// per failure-table read, bounded by earlier advances, and finishes into the result
// register once it is free. The next byte is fetched only after that. After a
// configuration write the table is rebuilt; queued bytes wait meanwhile. A two-entry
// queue and the result register let input and output stall independently. Reset
// loads the CR LF pattern with an empty table.
`default_nettype none
`include "kmp_stream_pattern_matcher_assert.svh"
module kmp_stream_pattern_matcher (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,    // data_byte[7:0]
	input  wire logic         s_tlast,    // last_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [23:0]       m_tdata,    // match_here[0], match_start[16:1], no_match[17]
	output logic              m_tlast,    // text_end
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [63:0]  cfg_wdata
);
	import kmp_pkg::*;

	logic [PAT_W-1:0]  pattern_q;
	logic [LEN_W-1:0]  length_q;
	cfg_t              cfg;
	tbl_stat_t         tbl_stat;
	logic [IDX_W-1:0]  tbl_idx;
	logic [IDX_W-1:0]  tbl_data;
	logic              q_valid;
	item_t             q_item;
	logic              q_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PATTERN_RESET;
			length_q  <= LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN: pattern_q <= cfg_wdata;
				REG_LENGTH:  length_q  <= cfg_wdata[LEN_W-1:0];
				default:     pattern_q <= pattern_q;
			endcase
		end
	end

	assign cfg.pattern = pattern_q;
	assign cfg.len     = eff_len(length_q);

	kmp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	kmp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.cfg     (cfg),
		.rd_idx  (tbl_idx),
		.rd_data (tbl_data),
		.stat    (tbl_stat)
	);

	kmp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_we),
		.cfg      (cfg),
		.tbl_stat (tbl_stat),
		.tbl_idx  (tbl_idx),
		.tbl_data (tbl_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Matcher never fetches a byte while the table is being rebuilt
	`KMP_ASSERT_NOW(a_no_fetch_busy, clk, arst_n, tbl_stat.busy, !q_pop, "byte fetched during table rebuild")
	// No-match flag only on the last byte of a text
	`KMP_ASSERT_NOW(a_nomatch_last, clk, arst_n, m_tvalid && m_tdata[17], m_tlast, "no_match on a byte that is not last")
	// A hit and a no-match report never come together
	`KMP_ASSERT_NOW(a_hit_excl, clk, arst_n, m_tvalid && m_tdata[0], !m_tdata[17], "match and no_match in one result")
	// A configuration write starts a table rebuild
	`KMP_ASSERT_NEXT(a_cfg_rebuild, clk, arst_n, cfg_we, tbl_stat.busy, "table rebuild did not start")

endmodule
`default_nettype wire

/* sv/kmp_front.sv */
// Input side: accepts text bytes and queues them for the matcher.
`default_nettype none
module kmp_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,   // data_byte[7:0]
	input  wire logic                       s_tlast,   // last_byte
	output logic                            q_valid,
	output kmp_pkg::item_t                  q_item,
	input  wire logic                       q_pop
);
	import kmp_pkg::*;

	item_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;

	// Handshake and queue flags
	assign s_tready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	// Store the request in the queue
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data: s_tdata, last: s_tlast};
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/kmp_table.sv */
// Prefix-failure table with its builder, rebuilt after each configuration write.
`default_nettype none
module kmp_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        restart,
	input  wire kmp_pkg::cfg_t               cfg,
	input  wire logic [kmp_pkg::IDX_W-1:0]   rd_idx,
	output logic      [kmp_pkg::IDX_W-1:0]   rd_data,
	output kmp_pkg::tbl_stat_t               stat
);
	import kmp_pkg::*;

	logic [IDX_W-1:0]  ft_q [PATTERN_MAX];
	tbl_state_t        state_q, state_d;
	logic [LEN_W-1:0]  i_q, i_d;
	logic [IDX_W-1:0]  j_q, j_d;
	logic [IDX_W-1:0]  rd_addr;
	logic              eq;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_val;

	// Single read port shared by builder and matcher
	assign rd_addr   = (state_q == TB_RUN) ? (j_q - IDX_W'(1)) : rd_idx;
	assign rd_data   = ft_q[rd_addr];
	assign stat.busy = (state_q == TB_RUN);
	assign eq        = (pat_byte(cfg.pattern, i_q[IDX_W-1:0]) == pat_byte(cfg.pattern, j_q));
	assign wr_val    = j_q + IDX_W'(eq);

	// Builder state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TB_IDLE;
			i_q     <= LEN_W'(1);
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	// Next state: one fallback or one table entry per cycle
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		wr_en   = 1'b0;
		if (restart) begin
			state_d = TB_RUN;
			i_d     = LEN_W'(1);
			j_d     = '0;
		end else begin
			case (state_q)
				TB_RUN: begin
					if (i_q >= cfg.len) begin
						state_d = TB_IDLE;
					end else if ((j_q != '0) && !eq) begin
						j_d = rd_data;
					end else begin
						wr_en = 1'b1;
						j_d   = wr_val;
						i_d   = i_q + LEN_W'(1);
					end
				end
				default: begin
					state_d = TB_IDLE;
				end
			endcase
		end
	end

	// Clear the table on restart, then fill one entry at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				ft_q[k] <= '0;
			end
		end else if (restart) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				ft_q[k] <= '0;
			end
		end else if (wr_en) begin
			ft_q[i_q[IDX_W-1:0]] <= wr_val;
		end
	end

endmodule
`default_nettype wire

/* sv/kmp_back.sv */
// Matcher side: runs the KMP step per byte and holds the result register.
`default_nettype none
module kmp_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        restart,
	input  wire kmp_pkg::cfg_t               cfg,
	input  wire kmp_pkg::tbl_stat_t          tbl_stat,
	output logic      [kmp_pkg::IDX_W-1:0]   tbl_idx,
	input  wire logic [kmp_pkg::IDX_W-1:0]   tbl_data,
	input  wire logic                        q_valid,
	input  wire kmp_pkg::item_t              q_item,
	output logic                             q_pop,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [kmp_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);
	import kmp_pkg::*;

	back_state_t        state_q, state_d;
	logic [BYTE_W-1:0]  byte_q;
	logic               last_q;
	logic [IDX_W-1:0]   matched_q, matched_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic               seen_q, seen_d;
	logic               out_valid_q;
	logic               hit_q;
	logic [POS_W-1:0]   start_q;
	logic               nomatch_q;
	logic               end_q;

	logic               searching;
	logic               eq;
	logic [LEN_W-1:0]   jn;
	logic               hit;
	logic               out_free;
	logic               finish;
	logic               load;

	// KMP step on the current byte
	assign searching = !seen_q && (cfg.len != '0);
	assign eq        = (byte_q == pat_byte(cfg.pattern, matched_q));
	assign jn        = {1'b0, matched_q} + LEN_W'(eq);
	assign hit       = searching && (jn == cfg.len);
	assign tbl_idx   = matched_q - IDX_W'(1);
	assign out_free  = !out_valid_q || m_tready;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			matched_q <= '0;
			pos_q     <= '0;
			seen_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			matched_q <= matched_d;
			pos_q     <= pos_d;
			seen_q    <= seen_d;
		end
	end

	// Next state: fetch, fall back, then finish into the result register
	always_comb begin
		state_d   = state_q;
		matched_d = matched_q;
		pos_d     = pos_q;
		seen_d    = seen_q;
		q_pop     = 1'b0;
		finish    = 1'b0;
		load      = 1'b0;
		if (restart) begin
			state_d   = BK_IDLE;
			matched_d = '0;
			pos_d     = '0;
			seen_d    = 1'b0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (q_valid && !tbl_stat.busy) begin
						q_pop   = 1'b1;
						load    = 1'b1;
						state_d = BK_SCAN;
					end
				end
				BK_SCAN: begin
					if (searching && (matched_q != '0) && !eq) begin
						matched_d = tbl_data;
					end else if (out_free) begin
						finish  = 1'b1;
						state_d = BK_IDLE;
						if (hit) begin
							matched_d = '0;
							seen_d    = 1'b1;
						end else if (searching) begin
							matched_d = jn[IDX_W-1:0];
						end
						if (last_q) begin
							matched_d = '0;
							pos_d     = '0;
							seen_d    = 1'b0;
						end else if (pos_q != POS_CAP) begin
							pos_d = pos_q + POS_W'(1);
						end
					end
				end
				default: begin
					state_d = BK_IDLE;
				end
			endcase
		end
	end

	// Hold the byte being matched
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= q_item.data;
			last_q <= q_item.last;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q     <= hit;
			start_q   <= hit ? (pos_q + POS_W'(1) - POS_W'(cfg.len)) : '0;
			nomatch_q <= last_q && !(seen_q || hit);
			end_q     <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = end_q;
	assign m_tdata  = {{(OUT_DATA_W - POS_W - 2){1'b0}}, nomatch_q, start_q, hit_q};

endmodule
`default_nettype wire
